// ===== src/dlr_pkg.sv =====
// Shared constants and types for the DDA line rasterizer.
package dlr_pkg;

    localparam int COORD_BITS_DEF = 11;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int COLOR_BITS_DEF = 24;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV_X,
        S_DIV_Y
    } t_state;

endpackage

// ===== src/dlr_in_if.sv =====
// Input channel: line start or step command word.
interface dlr_in_if #(
    parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
    parameter int COLOR_BITS = dlr_pkg::COLOR_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic [COLOR_BITS-1:0] line_color;

    modport source (
        output valid, mode, x_start, y_start, x_end, y_end, line_color,
        input  ready
    );
    modport sink (
        input  valid, mode, x_start, y_start, x_end, y_end, line_color,
        output ready
    );
endinterface

// ===== src/dlr_out_if.sv =====
// Output channel: one pixel word per command.
interface dlr_out_if #(
    parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
    parameter int COLOR_BITS = dlr_pkg::COLOR_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  is_last;
    logic                  is_valid;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, is_last, is_valid,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, is_last, is_valid,
        output ready
    );
endinterface

// ===== src/dlr_div.sv =====
// Restoring divider, one quotient bit per cycle, for (num << FRAC_BITS) / den with num <= den.
module dlr_div #(
    parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [COORD_BITS-1:0] i_num,
    input  logic [COORD_BITS-1:0] i_den,
    output logic                 o_done,
    output logic [FRAC_BITS:0]   o_quo
);
    import dlr_pkg::*;

    localparam int REM_W = COORD_BITS + 1;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic [REM_W-1:0]      r_rem, n_rem;
    logic [COORD_BITS-1:0] r_den;
    logic [FRAC_BITS:0]    r_quo, n_quo;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [REM_W-1:0]      den_ext;
    logic [REM_W-1:0]      diff;
    logic                  ge;

    assign den_ext = {1'b0, r_den};
    assign ge      = (r_rem >= den_ext);
    assign diff    = r_rem - den_ext;
    assign n_rem   = ge ? {diff[REM_W-2:0], 1'b0} : {r_rem[REM_W-2:0], 1'b0};
    assign n_quo   = {r_quo[FRAC_BITS-1:0], ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(FRAC_BITS)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== src/dda_line_rasterizer.sv =====
// DDA line rasterizer top level: command decode, accumulators, output register.
//
// Usage:
//   i_in carries command words. mode=0 starts a line from (x_start, y_start)
//   to (x_end, y_end) with line_color; mode=1 asks for the next pixel.
//   o_out carries exactly one pixel word per command, in order. A step with
//   no line active returns a word with is_valid=0 and all fields zero; the
//   final pixel of a line has is_last=1.
// Timing:
//   The result of any command appears in the output register in the cycle
//   after it is taken. Steps stream at one word per cycle while the output
//   is not stalled. A start command with distinct endpoints keeps the input
//   closed while the single restoring divider produces the x increment,
//   then the y increment. Equal endpoints need no division.
// Reset:
//   Synchronous, active low; the block comes up idle with no line active.
// Backpressure:
//   The output register holds a word until taken; a new command is taken
//   only when the register is empty or being drained in the same cycle.
module dda_line_rasterizer #(
    parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF,
    parameter int COLOR_BITS = dlr_pkg::COLOR_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dlr_in_if.sink    i_in,
    dlr_out_if.source o_out
);
    import dlr_pkg::*;

    localparam int ACC_W = COORD_BITS + FRAC_BITS + 1;
    localparam int INC_W = FRAC_BITS + 2;
    localparam int D_W   = COORD_BITS + 1;

    t_state r_state, n_state;

    logic [ACC_W-1:0]      r_acc_x, r_acc_y;
    logic [INC_W-1:0]      r_step_x, r_step_y;
    logic [COORD_BITS-1:0] r_steps_left;
    logic [COLOR_BITS-1:0] r_color;
    logic [COORD_BITS-1:0] r_ady;
    logic                  r_neg_x, r_neg_y;

    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_px, r_py;
    logic [COLOR_BITS-1:0] r_pcolor;
    logic                  r_last, r_pvalid;

    logic                  in_ready, accept, out_free, start_go;
    logic [D_W-1:0]        dx, dy;
    logic [COORD_BITS-1:0] adx, ady, steps;
    logic                  div_start, div_done;
    logic [COORD_BITS-1:0] div_num, div_den;
    logic [FRAC_BITS:0]    div_quo;
    logic [INC_W-1:0]      quo_ext, inc_signed;
    logic                  cur_neg;
    logic [ACC_W-1:0]      n_acc_x, n_acc_y, rnd_x, rnd_y;
    logic [ACC_W-1:0]      half;

    assign out_free = !r_out_valid || o_out.ready;
    assign accept   = i_in.valid && in_ready;

    assign dx    = {1'b0, i_in.x_end} - {1'b0, i_in.x_start};
    assign dy    = {1'b0, i_in.y_end} - {1'b0, i_in.y_start};
    assign adx   = dx[D_W-1] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    assign ady   = dy[D_W-1] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    assign steps = (adx > ady) ? adx : ady;

    assign start_go = accept && (i_in.mode == MODE_START) && (steps != '0);

    assign quo_ext    = {1'b0, div_quo};
    assign cur_neg    = (r_state == S_DIV_X) ? r_neg_x : r_neg_y;
    assign inc_signed = cur_neg ? -quo_ext : quo_ext;

    assign half    = ACC_W'(1) << (FRAC_BITS - 1);
    assign n_acc_x = r_acc_x + {{(ACC_W-INC_W){r_step_x[INC_W-1]}}, r_step_x};
    assign n_acc_y = r_acc_y + {{(ACC_W-INC_W){r_step_y[INC_W-1]}}, r_step_y};
    assign rnd_x   = n_acc_x + half;
    assign rnd_y   = n_acc_y + half;

    dlr_div #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_done (div_done),
        .o_quo  (div_quo)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start_go) n_state = S_DIV_X;
            end
            S_DIV_X: begin
                if (div_done) n_state = S_DIV_Y;
            end
            S_DIV_Y: begin
                if (div_done) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        div_num   = adx;
        div_den   = steps;
        unique case (r_state)
            S_IDLE: begin
                in_ready  = out_free;
                div_start = start_go;
            end
            S_DIV_X: begin
                div_start = div_done;
                div_num   = r_ady;
                div_den   = r_steps_left;
            end
            S_DIV_Y: begin
                div_den   = r_steps_left;
            end
            default: begin
                in_ready  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_steps_left <= '0;
            r_acc_x      <= '0;
            r_acc_y      <= '0;
            r_step_x     <= '0;
            r_step_y     <= '0;
            r_color      <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (r_state == S_DIV_X && div_done) r_step_x <= inc_signed;
            if (r_state == S_DIV_Y && div_done) r_step_y <= inc_signed;

            if (accept) begin
                if (i_in.mode == MODE_START) begin
                    r_acc_x      <= {1'b0, i_in.x_start, {FRAC_BITS{1'b0}}};
                    r_acc_y      <= {1'b0, i_in.y_start, {FRAC_BITS{1'b0}}};
                    r_color      <= i_in.line_color;
                    r_steps_left <= steps;
                    r_step_x     <= '0;
                    r_step_y     <= '0;
                end else if (r_steps_left != '0) begin
                    r_acc_x      <= n_acc_x;
                    r_acc_y      <= n_acc_y;
                    r_steps_left <= r_steps_left - 1'b1;
                end
            end
        end
    end

    // payload of the division and of the output word
    always_ff @(posedge i_clk) begin
        if (start_go) begin
            r_ady   <= ady;
            r_neg_x <= dx[D_W-1];
            r_neg_y <= dy[D_W-1];
        end
        if (accept) begin
            if (i_in.mode == MODE_START) begin
                r_px     <= i_in.x_start;
                r_py     <= i_in.y_start;
                r_pcolor <= i_in.line_color;
                r_last   <= (steps == '0);
                r_pvalid <= 1'b1;
            end else if (r_steps_left != '0) begin
                r_px     <= rnd_x[FRAC_BITS +: COORD_BITS];
                r_py     <= rnd_y[FRAC_BITS +: COORD_BITS];
                r_pcolor <= r_color;
                r_last   <= (r_steps_left == COORD_BITS'(1));
                r_pvalid <= 1'b1;
            end else begin
                r_px     <= '0;
                r_py     <= '0;
                r_pcolor <= '0;
                r_last   <= 1'b0;
                r_pvalid <= 1'b0;
            end
        end
    end

    assign i_in.ready        = in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.pixel_x     = r_px;
    assign o_out.pixel_y     = r_py;
    assign o_out.pixel_color = r_pcolor;
    assign o_out.is_last     = r_last;
    assign o_out.is_valid    = r_pvalid;

endmodule
